// ----- design/point_in_polygon_winding_macros.svh -----
// assertion macros shared by the checker
`ifndef POINT_IN_POLYGON_WINDING_MACROS_SVH
`define POINT_IN_POLYGON_WINDING_MACROS_SVH

// same-cycle implication, off during reset
`define PPW_ASSERT_NOW(lbl, clk, rst_n, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error("ppw check failed");

// next-cycle implication, off during reset
`define PPW_ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error("ppw check failed");

`endif

// ----- design/ppw_pkg.sv -----
package ppw_pkg;

	// table size and coordinate format
	localparam int MAX_VERTICES = 64;
	localparam int COORD_WIDTH  = 16;
	localparam int MIN_VERTICES = 3;

	// fixed field widths
	localparam int CNT_W  = 7;
	localparam int VIDX_W = 6;
	localparam int SUM_W  = 7;

	// derived widths
	localparam int STEP_W = $clog2(MAX_VERTICES + 1);
	localparam int CMP_W  = (STEP_W > CNT_W) ? STEP_W : CNT_W;
	localparam int DIFF_W = COORD_WIDTH + 1;
	localparam int PROD_W = 2 * DIFF_W;
	localparam int CMPD_W = PROD_W + 1;

	typedef enum logic {
		CMD_LOAD  = 1'b0,
		CMD_QUERY = 1'b1
	} cmd_t;

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_WALK,
		ST_DRAIN
	} state_t;

	typedef struct packed {
		logic signed [COORD_WIDTH-1:0] x;
		logic signed [COORD_WIDTH-1:0] y;
	} vertex_t;

	// one edge handed to the edge unit
	typedef struct packed {
		logic    valid;
		logic    last;
		vertex_t prev;
		vertex_t cur;
	} edge_beat_t;

	// edge unit status back to the sequencer
	typedef struct packed {
		logic                    done;
		logic signed [SUM_W-1:0] sum;
	} edge_res_t;

endpackage

// ----- design/ppw_cell.sv -----
module ppw_cell (
	input  logic              clk,
	input  logic              we,
	input  ppw_pkg::vertex_t  wdata,
	input  logic              shift,
	input  ppw_pkg::vertex_t  nxt,
	output ppw_pkg::vertex_t  v
);

	ppw_pkg::vertex_t v_q;

	// load from the write port or take the neighbor's vertex while the ring turns
	always_ff @(posedge clk) begin
		if (we) begin
			v_q <= wdata;
		end else if (shift) begin
			v_q <= nxt;
		end
	end

	assign v = v_q;

endmodule

// ----- design/ppw_edge.sv -----
module ppw_edge (
	input  logic                                   clk,
	input  logic                                   arst_n,
	input  logic                                   clear,
	input  ppw_pkg::edge_beat_t                    beat,
	input  logic signed [ppw_pkg::COORD_WIDTH-1:0] px,
	input  logic signed [ppw_pkg::COORD_WIDTH-1:0] py,
	output ppw_pkg::edge_res_t                     res
);

	logic signed [ppw_pkg::DIFF_W-1:0] a_s1, dy_s1, c_s1, d_s1;
	logic                              strad_s1, vld_s1, last_s1;
	logic signed [ppw_pkg::PROD_W-1:0] pl_s2, pr_s2;
	logic                              strad_s2, dyneg_s2, vld_s2, last_s2;
	logic signed [ppw_pkg::CMPD_W-1:0] diff;
	logic                              hit;
	logic signed [ppw_pkg::SUM_W-1:0]  step, sum_next, sum_q;
	logic                              done_q;

	// stage 1: differences and the straddle test
	always_ff @(posedge clk) begin
		a_s1     <= ppw_pkg::DIFF_W'(px) - ppw_pkg::DIFF_W'(beat.cur.x);
		dy_s1    <= ppw_pkg::DIFF_W'(beat.prev.y) - ppw_pkg::DIFF_W'(beat.cur.y);
		c_s1     <= ppw_pkg::DIFF_W'(beat.prev.x) - ppw_pkg::DIFF_W'(beat.cur.x);
		d_s1     <= ppw_pkg::DIFF_W'(py) - ppw_pkg::DIFF_W'(beat.cur.y);
		strad_s1 <= (beat.cur.y > py) != (beat.prev.y > py);
	end

	// stage 2: the two cross products
	always_ff @(posedge clk) begin
		pl_s2    <= ppw_pkg::PROD_W'(a_s1) * ppw_pkg::PROD_W'(dy_s1);
		pr_s2    <= ppw_pkg::PROD_W'(c_s1) * ppw_pkg::PROD_W'(d_s1);
		strad_s2 <= strad_s1;
		dyneg_s2 <= dy_s1[ppw_pkg::DIFF_W-1];
	end

	// stage 3: crossing strictly right of the point, signed by edge direction
	always_comb begin
		diff = ppw_pkg::CMPD_W'(pl_s2) - ppw_pkg::CMPD_W'(pr_s2);
		if (dyneg_s2) begin
			hit = !diff[ppw_pkg::CMPD_W-1] && (diff != '0);
			step = ppw_pkg::SUM_W'(1);
		end else begin
			hit = diff[ppw_pkg::CMPD_W-1];
			step = '1;
		end
		sum_next = (vld_s2 && strad_s2 && hit) ? sum_q + step : sum_q;
	end

	// beat flags and the running sum
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1  <= 1'b0;
			last_s1 <= 1'b0;
			vld_s2  <= 1'b0;
			last_s2 <= 1'b0;
			sum_q   <= '0;
			done_q  <= 1'b0;
		end else begin
			vld_s1  <= beat.valid;
			last_s1 <= beat.last;
			vld_s2  <= vld_s1;
			last_s2 <= last_s1;
			done_q  <= last_s2;
			if (clear) begin
				sum_q <= '0;
			end else begin
				sum_q <= sum_next;
			end
		end
	end

	assign res.done = done_q;
	assign res.sum  = sum_q;

endmodule

// ----- design/point_in_polygon_winding.sv -----
// channel   direction  handshake                 payload
// input     in         start / busy              command, vertex_index, coord_x, coord_y
// result    out        done strobe, no stall     inside_res, winding_sum, too_few_vertices
// config    in         cfg_we                    cfg_data (vertex_count)
//
// A load beat leaves busy low.
// A query turns the 64-cell vertex ring once past the edge unit: the walk, the edge
// stages and the result register lie between, and done rises together with busy falling.
// With fewer than three vertices done comes in the cycle after the query is taken.
// arst_n clears control state and vertex_count; the vertex cells hold no reset value.
// The receiver cannot stall: each result shows on done for exactly one cycle.
module point_in_polygon_winding (
	input  logic                                   clk,
	input  logic                                   arst_n,
	input  logic                                   start,
	output logic                                   busy,
	input  logic                                   command,
	input  logic [ppw_pkg::VIDX_W-1:0]             vertex_index,
	input  logic signed [ppw_pkg::COORD_WIDTH-1:0] coord_x,
	input  logic signed [ppw_pkg::COORD_WIDTH-1:0] coord_y,
	input  logic                                   cfg_we,
	input  logic [ppw_pkg::CNT_W-1:0]              cfg_data,
	output logic                                   done,
	output logic                                   inside_res,
	output logic signed [ppw_pkg::SUM_W-1:0]       winding_sum,
	output logic                                   too_few_vertices
);

	ppw_pkg::state_t                   state_q, state_d;
	logic [ppw_pkg::CNT_W-1:0]         count_q;
	logic [ppw_pkg::CMP_W-1:0]         cnt_ext, n_eff, n_q, step_ext;
	logic [ppw_pkg::STEP_W-1:0]        step_q;
	logic signed [ppw_pkg::COORD_WIDTH-1:0] px_q, py_q;
	ppw_pkg::vertex_t                  first_q, prev_q, wvert, head;
	ppw_pkg::vertex_t                  cell_v [ppw_pkg::MAX_VERTICES];
	ppw_pkg::edge_beat_t               beat;
	ppw_pkg::edge_res_t                eres;
	logic                              accept, is_query, few, walking, shift, at_end;
	logic                              done_q, inside_q, too_few_q;
	logic signed [ppw_pkg::SUM_W-1:0]  sum_q;

	// input beat decode
	always_comb begin
		accept   = start && !busy;
		is_query = ppw_pkg::cmd_t'(command) == ppw_pkg::CMD_QUERY;
		cnt_ext  = ppw_pkg::CMP_W'(count_q);
		n_eff    = (cnt_ext > ppw_pkg::CMP_W'(ppw_pkg::MAX_VERTICES)) ?
			ppw_pkg::CMP_W'(ppw_pkg::MAX_VERTICES) : cnt_ext;
		few      = cnt_ext < ppw_pkg::CMP_W'(ppw_pkg::MIN_VERTICES);
		wvert.x  = coord_x;
		wvert.y  = coord_y;
	end

	// vertex ring: cell 0 is the head, each cell takes its upper neighbor
	for (genvar k = 0; k < ppw_pkg::MAX_VERTICES; k++) begin : g_cell
		ppw_cell u_cell (
			.clk   (clk),
			.we    (accept && !is_query && (int'(vertex_index) == k)),
			.wdata (wvert),
			.shift (shift),
			.nxt   (cell_v[(k + 1) % ppw_pkg::MAX_VERTICES]),
			.v     (cell_v[k])
		);
	end

	assign head = cell_v[0];

	// next state
	always_comb begin
		state_d = state_q;
		unique case (state_q)
			ppw_pkg::ST_IDLE: begin
				if (accept && is_query && !few) begin
					state_d = ppw_pkg::ST_WALK;
				end
			end
			ppw_pkg::ST_WALK: begin
				if (at_end) begin
					state_d = ppw_pkg::ST_DRAIN;
				end
			end
			ppw_pkg::ST_DRAIN: begin
				if (eres.done) begin
					state_d = ppw_pkg::ST_IDLE;
				end
			end
			default: state_d = ppw_pkg::ST_IDLE;
		endcase
	end

	// state outputs
	always_comb begin
		busy    = 1'b1;
		walking = 1'b0;
		unique case (state_q)
			ppw_pkg::ST_IDLE:  busy = 1'b0;
			ppw_pkg::ST_WALK:  walking = 1'b1;
			ppw_pkg::ST_DRAIN: walking = 1'b0;
			default:           busy = 1'b1;
		endcase
	end

	// walk control: one ring step per cycle, closing edge back to the saved first vertex
	always_comb begin
		step_ext  = ppw_pkg::CMP_W'(step_q);
		at_end    = step_ext == ppw_pkg::CMP_W'(ppw_pkg::MAX_VERTICES);
		shift     = walking && !at_end;
		beat.prev = prev_q;
		beat.cur  = (step_ext == n_q) ? first_q : head;
		beat.valid = walking && (step_q != '0) && (step_ext <= n_q);
		beat.last  = walking && at_end;
	end

	ppw_edge u_edge (
		.clk    (clk),
		.arst_n (arst_n),
		.clear  (accept && is_query),
		.beat   (beat),
		.px     (px_q),
		.py     (py_q),
		.res    (eres)
	);

	// query operands and ring bookkeeping
	always_ff @(posedge clk) begin
		if (accept && is_query) begin
			px_q <= coord_x;
			py_q <= coord_y;
			n_q  <= n_eff;
		end
		if (walking && (step_ext < n_q)) begin
			prev_q <= head;
		end
		if (walking && (step_q == '0)) begin
			first_q <= head;
		end
	end

	// control registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ppw_pkg::ST_IDLE;
			step_q  <= '0;
			count_q <= '0;
			done_q  <= 1'b0;
		end else begin
			state_q <= state_d;
			if (cfg_we) begin
				count_q <= cfg_data;
			end
			if (walking) begin
				step_q <= step_q + ppw_pkg::STEP_W'(1);
			end else begin
				step_q <= '0;
			end
			done_q <= eres.done || (accept && is_query && few);
		end
	end

	// result beat
	always_ff @(posedge clk) begin
		if (eres.done) begin
			sum_q     <= eres.sum;
			inside_q  <= eres.sum != '0;
			too_few_q <= 1'b0;
		end else if (accept && is_query && few) begin
			sum_q     <= '0;
			inside_q  <= 1'b0;
			too_few_q <= 1'b1;
		end
	end

	assign done             = done_q;
	assign inside_res       = inside_q;
	assign winding_sum      = sum_q;
	assign too_few_vertices = too_few_q;

endmodule

// ----- design/ppw_checker.sv -----
`include "point_in_polygon_winding_macros.svh"

module ppw_checker (
	input logic                                   clk,
	input logic                                   arst_n,
	input logic                                   start,
	input logic                                   busy,
	input logic                                   command,
	input logic                                   done,
	input logic                                   inside_res,
	input logic signed [ppw_pkg::SUM_W-1:0]       winding_sum,
	input logic                                   too_few_vertices
);

	logic load_beat, query_beat;

	assign load_beat  = start && !busy && (ppw_pkg::cmd_t'(command) == ppw_pkg::CMD_LOAD);
	assign query_beat = start && !busy && (ppw_pkg::cmd_t'(command) == ppw_pkg::CMD_QUERY);

	// inside flag follows the winding sum
	`PPW_ASSERT_NOW(a_inside_sum, clk, arst_n, done, inside_res == (winding_sum != '0))
	// a short polygon reports a clean outside
	`PPW_ASSERT_NOW(a_few_clean, clk, arst_n, done && too_few_vertices, !inside_res && (winding_sum == '0))
	// a load beat never produces a result
	`PPW_ASSERT_NEXT(a_load_quiet, clk, arst_n, load_beat, !done)
	// a query either walks or answers at once
	`PPW_ASSERT_NEXT(a_query_moves, clk, arst_n, query_beat, busy || (done && too_few_vertices))

endmodule

bind point_in_polygon_winding ppw_checker u_ppw_checker (
	.clk              (clk),
	.arst_n           (arst_n),
	.start            (start),
	.busy             (busy),
	.command          (command),
	.done             (done),
	.inside_res       (inside_res),
	.winding_sum      (winding_sum),
	.too_few_vertices (too_few_vertices)
);

// ----- tb/tb_top.sv -----
`timescale 1ns / 100ps

module tb_top;
	import ppw_pkg::*;

	// query walk plus edge stages plus result register, with margin
	localparam int QUERY_LATENCY  = MAX_VERTICES + 16;
	localparam int WATCHDOG_LIMIT = 4000;
	localparam int ITEM_TARGET    = 1700;

	typedef logic signed [COORD_WIDTH-1:0] coord_t;

	// one expected query answer
	typedef struct {
		logic                    in_poly;
		logic signed [SUM_W-1:0] sum;
		logic                    few;
	} verdict_t;

	logic                    clk;
	logic                    arst_n;
	logic                    start;
	logic                    busy;
	logic                    command;
	logic [VIDX_W-1:0]       vertex_index;
	coord_t                  coord_x;
	coord_t                  coord_y;
	logic                    cfg_we;
	logic [CNT_W-1:0]        cfg_data;
	logic                    done;
	logic                    inside_res;
	logic signed [SUM_W-1:0] winding_sum;
	logic                    too_few_vertices;

	// shadow polygon and count
	coord_t           poly_x [MAX_VERTICES];
	coord_t           poly_y [MAX_VERTICES];
	logic [CNT_W-1:0] poly_count;

	verdict_t pending_verdicts [$];
	int       failures;
	int       beats_sent;
	int       burst_left;
	int       stall_cycles;

	// random region for polygon vertices and probe points
	int box_x_lo;
	int box_y_lo;
	int box_span;

	point_in_polygon_winding uut (
		.clk              (clk),
		.arst_n           (arst_n),
		.start            (start),
		.busy             (busy),
		.command          (command),
		.vertex_index     (vertex_index),
		.coord_x          (coord_x),
		.coord_y          (coord_y),
		.cfg_we           (cfg_we),
		.cfg_data         (cfg_data),
		.done             (done),
		.inside_res       (inside_res),
		.winding_sum      (winding_sum),
		.too_few_vertices (too_few_vertices)
	);

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	// nonzero winding rule with exact cross-multiplied crossing test
	function automatic verdict_t winding_of(input coord_t px, input coord_t py);
		verdict_t v;
		int       n;
		int       total;
		int       i;
		int       j;
		longint   xi;
		longint   yi;
		longint   xj;
		longint   yj;
		longint   dy;
		longint   lhs;
		longint   rhs;
		logic     right;
		n = (poly_count > MAX_VERTICES) ? MAX_VERTICES : int'(poly_count);
		if (n < MIN_VERTICES) begin
			v.in_poly = 1'b0;
			v.sum     = '0;
			v.few     = 1'b1;
			return v;
		end
		total = 0;
		j = n - 1;
		for (i = 0; i < n; i++) begin
			xi = poly_x[i];
			yi = poly_y[i];
			xj = poly_x[j];
			yj = poly_y[j];
			if ((yi > py) != (yj > py)) begin
				dy    = yj - yi;
				lhs   = (px - xi) * dy;
				rhs   = (xj - xi) * (py - yi);
				right = (dy > 0) ? (lhs < rhs) : (lhs > rhs);
				if (right)
					total += (yi > yj) ? 1 : -1;
			end
			j = i;
		end
		v.in_poly = (total != 0);
		v.sum     = SUM_W'(total);
		v.few     = 1'b0;
		return v;
	endfunction

	// send one beat in bursts with random gaps, update shadow state on accept
	task automatic send_beat(input cmd_t op, input logic [VIDX_W-1:0] slot,
			input coord_t x, input coord_t y);
		int gap;
		if (burst_left == 0) begin
			gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
			if (gap > 0) begin
				start <= 1'b0;
				repeat (gap) @(posedge clk);
			end
			burst_left = $urandom_range(1, 24);
		end
		burst_left--;
		start        <= 1'b1;
		command      <= op;
		vertex_index <= slot;
		coord_x      <= x;
		coord_y      <= y;
		do @(posedge clk); while (busy !== 1'b0);
		if (op == CMD_LOAD) begin
			poly_x[slot] = x;
			poly_y[slot] = y;
		end else begin
			pending_verdicts.push_back(winding_of(x, y));
		end
		beats_sent++;
	endtask

	// hold off until every answer is back and the block has gone idle
	task automatic drain_results();
		start <= 1'b0;
		while (pending_verdicts.size() != 0) @(posedge clk);
		repeat (QUERY_LATENCY) @(posedge clk);
	endtask

	task automatic set_vertex_count(input int n);
		drain_results();
		cfg_we   <= 1'b1;
		cfg_data <= CNT_W'(n);
		@(posedge clk);
		cfg_we     <= 1'b0;
		poly_count = CNT_W'(n);
	endtask

	function automatic coord_t in_box_x();
		return coord_t'(box_x_lo + int'($urandom_range(0, box_span)));
	endfunction

	function automatic coord_t in_box_y();
		return coord_t'(box_y_lo + int'($urandom_range(0, box_span)));
	endfunction

	function automatic coord_t any_coord();
		return coord_t'($urandom_range(0, 65535));
	endfunction

	// probe point: mostly in the box, sometimes on vertices, edges, vertex rows or anywhere
	task automatic pick_point(input int n_used, output coord_t px, output coord_t py);
		int k;
		int m;
		k = (n_used > 0) ? $urandom_range(0, n_used - 1) : 0;
		m = (k + 1 < n_used) ? k + 1 : 0;
		px = in_box_x();
		py = in_box_y();
		case ($urandom_range(0, 9))
			0: if (n_used > 0) begin
				px = poly_x[k];
				py = poly_y[k];
			end
			1: if (n_used > 0) begin
				px = coord_t'((int'(poly_x[k]) + int'(poly_x[m])) / 2);
				py = coord_t'((int'(poly_y[k]) + int'(poly_y[m])) / 2);
			end
			2: begin
				px = any_coord();
				py = any_coord();
			end
			3: if (n_used > 0) py = poly_y[k];
			default: ;
		endcase
	endtask

	// zigzag whose down edges all cross just right of the origin (left of it for a negative ysign)
	task automatic load_zigzag(input int ysign);
		int k;
		for (k = 0; k < MAX_VERTICES - 1; k++) begin
			if (k % 2 == 0)
				send_beat(CMD_LOAD, VIDX_W'(k), coord_t'(-4 * (k / 2)), coord_t'(10 * ysign));
			else
				send_beat(CMD_LOAD, VIDX_W'(k), coord_t'(2 + 4 * (k / 2)),
					coord_t'(-10 * ysign));
		end
		send_beat(CMD_LOAD, VIDX_W'(MAX_VERTICES - 1), coord_t'(0), coord_t'(10 * ysign));
	endtask

	task automatic test_too_few_vertices();
		send_beat(CMD_QUERY, '0, coord_t'(-32768), coord_t'(32767));
		set_vertex_count(1);
		send_beat(CMD_QUERY, '1, coord_t'(32767), coord_t'(-32768));
		set_vertex_count(2);
		send_beat(CMD_QUERY, '0, coord_t'(0), coord_t'(0));
		set_vertex_count(0);
		send_beat(CMD_QUERY, '0, coord_t'(1), coord_t'(-1));
	endtask

	// full-range square, points at the center, on corners and on edges
	task automatic test_square_extremes();
		send_beat(CMD_LOAD, VIDX_W'(0), coord_t'(-32768), coord_t'(-32768));
		send_beat(CMD_LOAD, VIDX_W'(1), coord_t'(32767), coord_t'(-32768));
		send_beat(CMD_LOAD, VIDX_W'(2), coord_t'(32767), coord_t'(32767));
		send_beat(CMD_LOAD, VIDX_W'(3), coord_t'(-32768), coord_t'(32767));
		send_beat(CMD_LOAD, VIDX_W'(MAX_VERTICES - 1), coord_t'(1), coord_t'(-1));
		set_vertex_count(4);
		send_beat(CMD_QUERY, '0, coord_t'(0), coord_t'(0));
		send_beat(CMD_QUERY, '0, coord_t'(-32768), coord_t'(-32768));
		send_beat(CMD_QUERY, '0, coord_t'(32767), coord_t'(0));
		send_beat(CMD_QUERY, '0, coord_t'(-32768), coord_t'(0));
		send_beat(CMD_QUERY, '0, coord_t'(0), coord_t'(32767));
		send_beat(CMD_QUERY, '0, coord_t'(0), coord_t'(-32768));
		send_beat(CMD_QUERY, '0, coord_t'(-32768), coord_t'(32767));
	endtask

	// deep winding sums from the zigzag, both signs
	task automatic test_deep_winding();
		load_zigzag(1);
		set_vertex_count(MAX_VERTICES - 1);
		send_beat(CMD_QUERY, '0, coord_t'(0), coord_t'(0));
		send_beat(CMD_QUERY, '0, coord_t'(1), coord_t'(0));
		send_beat(CMD_QUERY, '0, coord_t'(0), coord_t'(20));
		send_beat(CMD_QUERY, '0, coord_t'(0), coord_t'(-10));
		set_vertex_count(MAX_VERTICES);
		send_beat(CMD_QUERY, '0, coord_t'(0), coord_t'(0));
		load_zigzag(-1);
		send_beat(CMD_QUERY, '0, coord_t'(0), coord_t'(0));
		send_beat(CMD_QUERY, '0, coord_t'(-1), coord_t'(0));
	endtask

	// counts past the table size behave as a full table
	task automatic test_count_saturation();
		set_vertex_count(MAX_VERTICES + 1);
		send_beat(CMD_QUERY, '0, coord_t'(0), coord_t'(0));
		set_vertex_count(127);
		send_beat(CMD_QUERY, '0, coord_t'(0), coord_t'(0));
		send_beat(CMD_QUERY, '0, coord_t'(0), coord_t'(5));
	endtask

	// random polygons, each followed by a batch of probes
	task automatic test_random_polygons();
		int     n;
		int     n_used;
		int     k;
		int     probes;
		coord_t px;
		coord_t py;
		while (beats_sent < ITEM_TARGET) begin
			case ($urandom_range(0, 24))
				0, 1:    n = $urandom_range(0, MIN_VERTICES - 1);
				2, 3:    n = $urandom_range(13, MAX_VERTICES);
				4:       n = $urandom_range(MAX_VERTICES + 1, 127);
				default: n = $urandom_range(MIN_VERTICES, 12);
			endcase
			n_used = (n > MAX_VERTICES) ? MAX_VERTICES : n;
			case ($urandom_range(0, 3))
				0, 1:    box_span = 8;
				2:       box_span = 4000;
				default: box_span = 65535;
			endcase
			box_x_lo = int'($urandom_range(0, 65535 - box_span)) - 32768;
			box_y_lo = int'($urandom_range(0, 65535 - box_span)) - 32768;
			for (k = 0; k < n_used; k++)
				send_beat(CMD_LOAD, VIDX_W'(k), in_box_x(), in_box_y());
			repeat ($urandom_range(0, 2))
				send_beat(CMD_LOAD, VIDX_W'($urandom), any_coord(), any_coord());
			set_vertex_count(n);
			probes = $urandom_range(3, 12);
			for (k = 0; k < probes; k++) begin
				if ($urandom_range(0, 7) == 0)
					send_beat(CMD_LOAD, VIDX_W'($urandom), any_coord(), any_coord());
				pick_point(n_used, px, py);
				send_beat(CMD_QUERY, VIDX_W'($urandom), px, py);
			end
		end
	endtask

	// compare each answer with the oldest expectation
	always @(posedge clk) begin : check_results
		verdict_t want;
		if (arst_n && done === 1'b1) begin
			if (pending_verdicts.size() == 0) begin
				$error("result beat with no query waiting");
				failures++;
			end else begin
				want = pending_verdicts.pop_front();
				if (inside_res !== want.in_poly) begin
					$error("inside_res: expected %0d, got %0d", want.in_poly, inside_res);
					failures++;
				end
				if (winding_sum !== want.sum) begin
					$error("winding_sum: expected %0d, got %0d", want.sum, winding_sum);
					failures++;
				end
				if (too_few_vertices !== want.few) begin
					$error("too_few_vertices: expected %0d, got %0d", want.few,
						too_few_vertices);
					failures++;
				end
			end
		end
	end

	// watchdog on cycles with no beat moving
	always @(posedge clk) begin
		if ((start && busy === 1'b0) || done === 1'b1 || cfg_we)
			stall_cycles <= 0;
		else
			stall_cycles <= stall_cycles + 1;
		if (stall_cycles >= WATCHDOG_LIMIT) begin
			$display("tb_top: FAIL");
			$finish;
		end
	end

	initial begin
		arst_n       <= 1'b0;
		start        <= 1'b0;
		command      <= CMD_LOAD;
		vertex_index <= '0;
		coord_x      <= '0;
		coord_y      <= '0;
		cfg_we       <= 1'b0;
		cfg_data     <= '0;
		stall_cycles <= 0;
		failures   = 0;
		beats_sent = 0;
		burst_left = 0;
		poly_count = '0;
		box_x_lo   = -4;
		box_y_lo   = -4;
		box_span   = 8;
		foreach (poly_x[k]) begin
			poly_x[k] = '0;
			poly_y[k] = '0;
		end
		repeat (2) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		test_too_few_vertices();
		test_square_extremes();
		test_deep_winding();
		test_count_saturation();
		test_random_polygons();

		drain_results();
		if (failures == 0)
			$display("tb_top: PASS");
		else
			$display("tb_top: FAIL");
		$finish;
	end

endmodule
